### rtl/imu_tilt_rate_conditioner_defines.svh
// Assertion macros shared by the tilt and rate conditioner RTL.
// No dependencies; include by bare file name.
`ifndef IMU_TILT_RATE_CONDITIONER_DEFINES_SVH
`define IMU_TILT_RATE_CONDITIONER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITRC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITRC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/itrc_pkg.sv
// Shared types, register codes and constants for the tilt and rate conditioner.
// No dependencies; the interfaces, the unit and the top level use it by scoped names.
package itrc_pkg;

   // Default datapath widths
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int STATE_WIDTH_DEF  = 24;

   // Fixed-point fraction bits of coefficients and gain
   localparam int COEF_FRAC = 16;
   localparam int GAIN_FRAC = 12;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_LP_COEF  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_HP_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_HP_COEF   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_LP_COEF   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_DEADZONE  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_LIMIT     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_GAIN    = 3'd6;

   // Register reset values
   localparam logic [15:0] ACCEL_LP_COEF_RST  = 16'd6554;
   localparam logic        GYRO_HP_ENABLE_RST = 1'b1;
   localparam logic [15:0] GYRO_HP_COEF_RST   = 16'd64000;
   localparam logic [15:0] GYRO_LP_COEF_RST   = 16'd13107;
   localparam logic [14:0] GYRO_DEADZONE_RST  = 15'd32;
   localparam logic [14:0] GYRO_LIMIT_RST     = 15'd16000;
   localparam logic [15:0] OUTPUT_GAIN_RST    = 16'd4096;

   // Multiply-add unit modes
   localparam logic [1:0] MODE_LP  = 2'd0;  // s + floor(d*c/2^16)
   localparam logic [1:0] MODE_HP  = 2'd1;  // floor(x*k/2^16), state saturation
   localparam logic [1:0] MODE_OUT = 2'd2;  // floor(s*gain/2^(12+frac)), sample saturation

   // Write-back destinations
   localparam logic [3:0] DEST_S1_ALONG   = 4'd0;
   localparam logic [3:0] DEST_S1_ACROSS  = 4'd1;
   localparam logic [3:0] DEST_S2_ALONG   = 4'd2;
   localparam logic [3:0] DEST_S2_ACROSS  = 4'd3;
   localparam logic [3:0] DEST_HP_OUT     = 4'd4;
   localparam logic [3:0] DEST_RLP_ALONG  = 4'd5;
   localparam logic [3:0] DEST_RLP_ACROSS = 4'd6;
   localparam logic [3:0] DEST_TILT_ALONG = 4'd7;
   localparam logic [3:0] DEST_TILT_ACROSS = 4'd8;
   localparam logic [3:0] DEST_RATE_ALONG = 4'd9;
   localparam logic [3:0] DEST_RATE_ACROSS = 4'd10;

   // Control word that travels with one operation through the unit
   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic [3:0] dest;
   } itrc_op_type;

endpackage

### rtl/itrc_if.sv
// Valid/ready channel interfaces for IMU sample words and conditioned result words.
// Depends on itrc_pkg for the default sample width.
interface itrc_req_if #(
   parameter int WIDTH = itrc_pkg::SAMPLE_WIDTH_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] accel_along;
   logic signed [WIDTH-1:0] accel_across;
   logic signed [WIDTH-1:0] rate_along_raw;
   logic signed [WIDTH-1:0] rate_across_raw;

   modport source (
      output valid, accel_along, accel_across, rate_along_raw, rate_across_raw,
      input  ready
   );
   modport sink (
      input  valid, accel_along, accel_across, rate_along_raw, rate_across_raw,
      output ready
   );
endinterface

interface itrc_rsp_if #(
   parameter int WIDTH = itrc_pkg::SAMPLE_WIDTH_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] tilt_along;
   logic signed [WIDTH-1:0] tilt_across;
   logic signed [WIDTH-1:0] rate_along;
   logic signed [WIDTH-1:0] rate_across;

   modport source (
      output valid, tilt_along, tilt_across, rate_along, rate_across,
      input  ready
   );
   modport sink (
      input  valid, tilt_along, tilt_across, rate_along, rate_across,
      output ready
   );
endinterface

### rtl/itrc_mac.sv
// Shared two-stage multiply, shift, add and saturate unit of the conditioner.
// Depends on itrc_pkg for the operation word, modes and fraction widths.
module itrc_mac #(
   parameter int SAMPLE_WIDTH = itrc_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = itrc_pkg::STATE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  itrc_pkg::itrc_op_type         op_in,
   input  logic signed [STATE_WIDTH+1:0] opa_in,
   input  logic [15:0]                   opb_in,
   input  logic signed [STATE_WIDTH-1:0] addend_in,
   output itrc_pkg::itrc_op_type         op_out,
   output logic signed [STATE_WIDTH-1:0] result_out
);
   localparam int AW        = STATE_WIDTH + 2;
   localparam int PW        = AW + 17;
   localparam int FRAC      = STATE_WIDTH - SAMPLE_WIDTH;
   localparam int OUT_SHIFT = itrc_pkg::GAIN_FRAC + FRAC;

   localparam logic signed [PW:0] STATE_HI =
      $signed({{(PW + 2 - STATE_WIDTH){1'b0}}, {(STATE_WIDTH - 1){1'b1}}});
   localparam logic signed [PW:0] STATE_LO = ~STATE_HI;
   localparam logic signed [PW:0] SAMPLE_HI =
      $signed({{(PW + 2 - SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}});
   localparam logic signed [PW:0] SAMPLE_LO = ~SAMPLE_HI;

   itrc_pkg::itrc_op_type         op_m_ff;
   logic signed [AW-1:0]          opa_ff;
   logic [15:0]                   opb_ff;
   logic signed [STATE_WIDTH-1:0] add_m_ff;

   itrc_pkg::itrc_op_type         op_w_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [STATE_WIDTH-1:0] add_w_ff;

   logic signed [PW-1:0]          shifted;
   logic signed [PW:0]            sum;

   // Control: advance the operation word through both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         op_m_ff <= '0;
         op_w_ff <= '0;
      end else begin
         op_m_ff <= op_in;
         op_w_ff <= op_m_ff;
      end
   end

   // Operand capture, then the product
   always_ff @(posedge clock) begin
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      add_m_ff <= addend_in;
      prod_ff  <= opa_ff * $signed({1'b0, opb_ff});
      add_w_ff <= add_m_ff;
   end

   // Floor shift of the product and addition of the state term
   always_comb begin
      if (op_w_ff.mode == itrc_pkg::MODE_OUT) begin
         shifted = prod_ff >>> OUT_SHIFT;
      end else begin
         shifted = prod_ff >>> itrc_pkg::COEF_FRAC;
      end
      sum = (PW + 1)'(shifted) + (PW + 1)'(add_w_ff);
   end

   // Saturate per mode; the low-pass mode and unknown modes keep the low bits of the sum
   always_comb begin
      case (op_w_ff.mode)
         itrc_pkg::MODE_LP: begin
            result_out = sum[STATE_WIDTH-1:0];
         end
         itrc_pkg::MODE_HP: begin
            if (sum > STATE_HI) begin
               result_out = STATE_WIDTH'(STATE_HI);
            end else if (sum < STATE_LO) begin
               result_out = STATE_WIDTH'(STATE_LO);
            end else begin
               result_out = STATE_WIDTH'(sum);
            end
         end
         itrc_pkg::MODE_OUT: begin
            if (sum > SAMPLE_HI) begin
               result_out = STATE_WIDTH'(SAMPLE_HI);
            end else if (sum < SAMPLE_LO) begin
               result_out = STATE_WIDTH'(SAMPLE_LO);
            end else begin
               result_out = STATE_WIDTH'(sum);
            end
         end
         default: begin
            result_out = sum[STATE_WIDTH-1:0];
         end
      endcase
   end

   assign op_out = op_w_ff;

endmodule

### rtl/imu_tilt_rate_conditioner.sv
// IMU tilt and rate conditioner: one request word in, one response word out.
// Each word runs eleven multiply-adds (ten with the high-pass filter off) in sequence
// through one shared two-stage unit. The request side is not ready while a word is
// in work; a finished response waits in its own register while the next request is
// accepted. Synchronous active-high reset clears filter state, primed flag and response
// valid, idles the sequencer and loads the configuration registers with reset values.
`include "imu_tilt_rate_conditioner_defines.svh"

module imu_tilt_rate_conditioner #(
   parameter int SAMPLE_WIDTH = itrc_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = itrc_pkg::STATE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   itrc_req_if.sink                             req_port,
   itrc_rsp_if.source                           rsp_port,
   input  logic                                 csr_we,
   input  logic [itrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [itrc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   localparam int W    = SAMPLE_WIDTH;
   localparam int S    = STATE_WIDTH;
   localparam int FRAC = S - W;
   localparam int AW   = S + 2;
   localparam int DW   = S + 17;

   // 1.2 g in the sample format, rounded to nearest
   localparam logic signed [W-1:0] ACL_HI = W'(((12 << (W - 2)) + 5) / 10);
   localparam logic signed [W-1:0] ACL_LO = -ACL_HI;

   // Sequencer states and steps
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [3:0] STEP_PREP      = 4'd0;
   localparam logic [3:0] STEP_S1_ALONG  = 4'd1;
   localparam logic [3:0] STEP_S1_ACROSS = 4'd2;
   localparam logic [3:0] STEP_HP        = 4'd3;
   localparam logic [3:0] STEP_S2_ALONG  = 4'd4;
   localparam logic [3:0] STEP_S2_ACROSS = 4'd5;
   localparam logic [3:0] STEP_RLP_ALONG = 4'd6;
   localparam logic [3:0] STEP_RLP_ACROSS = 4'd7;
   localparam logic [3:0] STEP_O_TALONG  = 4'd8;
   localparam logic [3:0] STEP_O_TACROSS = 4'd9;
   localparam logic [3:0] STEP_O_RALONG  = 4'd10;
   localparam logic [3:0] STEP_O_RACROSS = 4'd11;
   localparam logic [3:0] STEP_LAST      = 4'd13;

   // Configuration registers
   logic [15:0] accel_lp_coef_ff;
   logic        gyro_hp_enable_ff;
   logic [15:0] gyro_hp_coef_ff;
   logic [15:0] gyro_lp_coef_ff;
   logic [14:0] gyro_deadzone_ff;
   logic [14:0] gyro_limit_ff;
   logic [15:0] output_gain_ff;

   // Sequencer
   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       req_take;
   logic       rsp_load;
   logic       rsp_valid_ff, rsp_valid_in;

   // Captured request word
   logic signed [W-1:0] in_al_ff, in_ac_ff, in_ral_ff, in_rac_ff;

   // Filter state and per-word temporaries
   logic                primed_ff;
   logic signed [S-1:0] s1_al_ff, s1_ac_ff, s2_al_ff, s2_ac_ff;
   logic signed [W-1:0] hp_in_ff;
   logic signed [S-1:0] hp_out_ff, rlp_al_ff, rlp_ac_ff;
   logic signed [S-1:0] acl_al_ff, acl_ac_ff, dz_al_ff, dz_ac_ff;
   logic signed [S-1:0] acl_al_now, acl_ac_now, gyro_across;

   // Staged results and response register
   logic signed [W-1:0] res_tal_ff, res_tac_ff, res_ral_ff, res_rac_ff;
   logic signed [W-1:0] rsp_tal_ff, rsp_tac_ff, rsp_ral_ff, rsp_rac_ff;

   // Shared unit connections
   itrc_pkg::itrc_op_type op_issue, op_done;
   logic signed [AW-1:0]  opa;
   logic [15:0]           opb;
   logic signed [S-1:0]   addend;
   logic signed [S-1:0]   mac_result;

   // Clamp an accel sample to 1.2 g and move it to the state format
   function automatic logic signed [S-1:0] clamp_accel(input logic signed [W-1:0] v);
      logic signed [W-1:0] c;
      if (v > ACL_HI) begin
         c = ACL_HI;
      end else if (v < ACL_LO) begin
         c = ACL_LO;
      end else begin
         c = v;
      end
      return S'(c) <<< FRAC;
   endfunction

   // Shrinking deadzone followed by the symmetric limit, both in state format
   function automatic logic signed [S-1:0] dead_clamp(input logic signed [S-1:0] v,
                                                      input logic [14:0] dz,
                                                      input logic [14:0] lim);
      logic signed [DW-1:0] vx, d, l, r;
      vx = DW'(v);
      d  = $signed({{(DW - 15){1'b0}}, dz}) <<< FRAC;
      l  = $signed({{(DW - 15){1'b0}}, lim}) <<< FRAC;
      if (vx < d && vx > -d) begin
         r = '0;
      end else if (vx > 0) begin
         r = vx - d;
      end else begin
         r = vx + d;
      end
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return r[S-1:0];
   endfunction

   // Configuration writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_lp_coef_ff  <= itrc_pkg::ACCEL_LP_COEF_RST;
         gyro_hp_enable_ff <= itrc_pkg::GYRO_HP_ENABLE_RST;
         gyro_hp_coef_ff   <= itrc_pkg::GYRO_HP_COEF_RST;
         gyro_lp_coef_ff   <= itrc_pkg::GYRO_LP_COEF_RST;
         gyro_deadzone_ff  <= itrc_pkg::GYRO_DEADZONE_RST;
         gyro_limit_ff     <= itrc_pkg::GYRO_LIMIT_RST;
         output_gain_ff    <= itrc_pkg::OUTPUT_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            itrc_pkg::CSR_ACCEL_LP_COEF:  accel_lp_coef_ff  <= csr_wdata[15:0];
            itrc_pkg::CSR_GYRO_HP_ENABLE: gyro_hp_enable_ff <= csr_wdata[0];
            itrc_pkg::CSR_GYRO_HP_COEF:   gyro_hp_coef_ff   <= csr_wdata[15:0];
            itrc_pkg::CSR_GYRO_LP_COEF:   gyro_lp_coef_ff   <= csr_wdata[15:0];
            itrc_pkg::CSR_GYRO_DEADZONE:  gyro_deadzone_ff  <= csr_wdata[14:0];
            itrc_pkg::CSR_GYRO_LIMIT:     gyro_limit_ff     <= csr_wdata[14:0];
            itrc_pkg::CSR_OUTPUT_GAIN:    output_gain_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: idle, step through the schedule, then hand off the response word
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && (state_ff == ST_IDLE);
   assign rsp_load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               step_in  = STEP_PREP;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
               step_in  = STEP_PREP;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = STEP_PREP;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_PREP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_al_ff  <= req_port.accel_along;
         in_ac_ff  <= req_port.accel_across;
         in_ral_ff <= req_port.rate_along_raw;
         in_rac_ff <= req_port.rate_across_raw;
      end
   end

   assign acl_al_now  = clamp_accel(in_al_ff);
   assign acl_ac_now  = clamp_accel(in_ac_ff);
   assign gyro_across = gyro_hp_enable_ff ? hp_out_ff : (S'(in_rac_ff) <<< FRAC);

   // Issue each step's operation to the shared unit; none in the prep and tail steps
   always_comb begin
      op_issue = '0;
      opa      = '0;
      opb      = '0;
      addend   = '0;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_S1_ALONG: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_S1_ALONG};
               opa      = AW'(acl_al_ff) - AW'(s1_al_ff);
               opb      = accel_lp_coef_ff;
               addend   = s1_al_ff;
            end
            STEP_S1_ACROSS: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_S1_ACROSS};
               opa      = AW'(acl_ac_ff) - AW'(s1_ac_ff);
               opb      = accel_lp_coef_ff;
               addend   = s1_ac_ff;
            end
            STEP_HP: begin
               op_issue = '{valid: gyro_hp_enable_ff, mode: itrc_pkg::MODE_HP,
                            dest: itrc_pkg::DEST_HP_OUT};
               opa      = AW'(hp_out_ff) + ((AW'(in_rac_ff) - AW'(hp_in_ff)) <<< FRAC);
               opb      = gyro_hp_coef_ff;
            end
            STEP_S2_ALONG: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_S2_ALONG};
               opa      = AW'(s1_al_ff) - AW'(s2_al_ff);
               opb      = accel_lp_coef_ff;
               addend   = s2_al_ff;
            end
            STEP_S2_ACROSS: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_S2_ACROSS};
               opa      = AW'(s1_ac_ff) - AW'(s2_ac_ff);
               opb      = accel_lp_coef_ff;
               addend   = s2_ac_ff;
            end
            STEP_RLP_ALONG: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_RLP_ALONG};
               opa      = AW'(dz_al_ff) - AW'(rlp_al_ff);
               opb      = gyro_lp_coef_ff;
               addend   = rlp_al_ff;
            end
            STEP_RLP_ACROSS: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_LP,
                            dest: itrc_pkg::DEST_RLP_ACROSS};
               opa      = AW'(dz_ac_ff) - AW'(rlp_ac_ff);
               opb      = gyro_lp_coef_ff;
               addend   = rlp_ac_ff;
            end
            STEP_O_TALONG: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_OUT,
                            dest: itrc_pkg::DEST_TILT_ALONG};
               opa      = AW'(s2_al_ff);
               opb      = output_gain_ff;
            end
            STEP_O_TACROSS: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_OUT,
                            dest: itrc_pkg::DEST_TILT_ACROSS};
               opa      = AW'(s2_ac_ff);
               opb      = output_gain_ff;
            end
            STEP_O_RALONG: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_OUT,
                            dest: itrc_pkg::DEST_RATE_ALONG};
               opa      = AW'(rlp_al_ff);
               opb      = output_gain_ff;
            end
            STEP_O_RACROSS: begin
               op_issue = '{valid: 1'b1, mode: itrc_pkg::MODE_OUT,
                            dest: itrc_pkg::DEST_RATE_ACROSS};
               opa      = AW'(rlp_ac_ff);
               opb      = output_gain_ff;
            end
            default: begin
            end
         endcase
      end
   end

   itrc_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .op_in      (op_issue),
      .opa_in     (opa),
      .opb_in     (opb),
      .addend_in  (addend),
      .op_out     (op_done),
      .result_out (mac_result)
   );

   // Filter state: prime on the first word, track the high-pass input, write back results
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         s1_al_ff  <= '0;
         s1_ac_ff  <= '0;
         s2_al_ff  <= '0;
         s2_ac_ff  <= '0;
         hp_in_ff  <= '0;
         hp_out_ff <= '0;
         rlp_al_ff <= '0;
         rlp_ac_ff <= '0;
      end else begin
         if (state_ff == ST_RUN && step_ff == STEP_PREP && !primed_ff) begin
            s1_al_ff  <= acl_al_now;
            s2_al_ff  <= acl_al_now;
            s1_ac_ff  <= acl_ac_now;
            s2_ac_ff  <= acl_ac_now;
            hp_in_ff  <= in_rac_ff;
            primed_ff <= 1'b1;
         end
         if (state_ff == ST_RUN && step_ff == STEP_HP && gyro_hp_enable_ff) begin
            hp_in_ff <= in_rac_ff;
         end
         if (op_done.valid) begin
            case (op_done.dest)
               itrc_pkg::DEST_S1_ALONG:   s1_al_ff  <= mac_result;
               itrc_pkg::DEST_S1_ACROSS:  s1_ac_ff  <= mac_result;
               itrc_pkg::DEST_S2_ALONG:   s2_al_ff  <= mac_result;
               itrc_pkg::DEST_S2_ACROSS:  s2_ac_ff  <= mac_result;
               itrc_pkg::DEST_HP_OUT:     hp_out_ff <= mac_result;
               itrc_pkg::DEST_RLP_ALONG:  rlp_al_ff <= mac_result;
               itrc_pkg::DEST_RLP_ACROSS: rlp_ac_ff <= mac_result;
               default: begin
               end
            endcase
         end
      end
   end

   // Per-word temporaries and deadzones, staged results and the response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN && step_ff == STEP_PREP) begin
         acl_al_ff <= acl_al_now;
         acl_ac_ff <= acl_ac_now;
         dz_al_ff  <= dead_clamp(S'(in_ral_ff) <<< FRAC, gyro_deadzone_ff, gyro_limit_ff);
      end
      if (state_ff == ST_RUN && step_ff == STEP_RLP_ALONG) begin
         dz_ac_ff <= dead_clamp(gyro_across, gyro_deadzone_ff, gyro_limit_ff);
      end
      if (op_done.valid) begin
         case (op_done.dest)
            itrc_pkg::DEST_TILT_ALONG:  res_tal_ff <= mac_result[W-1:0];
            itrc_pkg::DEST_TILT_ACROSS: res_tac_ff <= mac_result[W-1:0];
            itrc_pkg::DEST_RATE_ALONG:  res_ral_ff <= mac_result[W-1:0];
            itrc_pkg::DEST_RATE_ACROSS: res_rac_ff <= mac_result[W-1:0];
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_tal_ff <= res_tal_ff;
         rsp_tac_ff <= res_tac_ff;
         rsp_ral_ff <= res_ral_ff;
         rsp_rac_ff <= res_rac_ff;
      end
   end

   // Response word
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.tilt_along  = rsp_tal_ff;
   assign rsp_port.tilt_across = rsp_tac_ff;
   assign rsp_port.rate_along  = rsp_ral_ff;
   assign rsp_port.rate_across = rsp_rac_ff;

   // Checks
   `ITRC_ASSERT_NEXT(a_take_starts_run, clock, reset, req_take,
      state_ff == ST_RUN && step_ff == STEP_PREP, "accepted word did not start the sequence")
   `ITRC_ASSERT_NOW(a_writeback_in_run, clock, reset, op_done.valid,
      state_ff == ST_RUN, "unit result outside the sequence")
   `ITRC_ASSERT_NEXT(a_load_shows_rsp, clock, reset, rsp_load,
      rsp_valid_ff && state_ff == ST_IDLE, "finished word not presented")

endmodule
